// ===== src/smbt_pkg.sv =====
// shared types, constants and helpers for the smb2 chunk tracker
package smbt_pkg;

  localparam int DEF_PENDING_ENTRIES = 16;
  localparam int DEF_LENGTH_BITS     = 24;
  localparam int OUT_LEN_W           = 24;

  localparam int HDR_BYTES     = 64;
  localparam int READ_REQ_MIN  = 48;
  localparam int WRITE_REQ_MIN = 32;
  localparam int READ_RSP_MIN  = 16;

  localparam logic [15:0] CMD_READ  = 16'd8;
  localparam logic [15:0] CMD_WRITE = 16'd9;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_e;

  // request from the parser to the pending table
  typedef struct packed {
    logic                 write;
    logic                 record;
    logic                 match;
    logic [63:0]          msg_id;
    logic [63:0]          hlo;
    logic [63:0]          hhi;
    logic [63:0]          fpos;
    logic [OUT_LEN_W-1:0] dstart;
    logic [OUT_LEN_W-1:0] dlen;
  } req_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           kind;
    logic [63:0]          msg_id;
    logic [63:0]          hlo;
    logic [63:0]          hhi;
    logic [63:0]          fpos;
    logic [OUT_LEN_W-1:0] dstart;
    logic [OUT_LEN_W-1:0] dlen;
  } res_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'hFE;
      2'd1:    m = 8'h53;
      2'd2:    m = 8'h4D;
      default: m = 8'h42;
    endcase
    return m;
  endfunction

endpackage

// ===== src/smb2_read_write_chunk_tracker.sv =====
// top level of the smb2 read/write chunk tracker
// Takes an SMB2 message stream one byte per cycle while in_ready is high,
// walks the chain of compound headers and reports file chunks: a client
// WRITE request gives a chunk directly, a client READ request is parked in
// a pending table under its message id and a server READ response with that
// id consumes it and gives a chunk; a read request that finds the table full
// and no entry with its id is reported as dropped. A new byte is accepted
// every cycle while in_ready is high; the pending table is a bank of flops
// searched by a parallel id compare in the same cycle, so the result of a
// byte is registered in the output register, or in the skid entry while
// the output stalls. A skid entry behind the output register takes one more
// result while the output stalls, so input keeps flowing through a stall until
// a second result is waiting; in_ready then stays low until the waiting result
// transaction is taken and the skid entry has moved into the output register.
module smb2_read_write_chunk_tracker import smbt_pkg::*; #(
  parameter int PENDING_ENTRIES = DEF_PENDING_ENTRIES,
  parameter int LENGTH_BITS     = DEF_LENGTH_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        direction_i,
  input  logic        start_of_message_i,
  input  logic [23:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] message_id_o,
  output logic [63:0] file_id_low_o,
  output logic [63:0] file_id_high_o,
  output logic [63:0] file_pos_o,
  output logic [23:0] payload_start_o,
  output logic [23:0] payload_len_o
);

  logic accept;
  req_t req;
  res_t res, out;

  // a byte transaction completes
  assign accept = in_valid_i && in_ready_o;

  // header and body field extraction
  smbt_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk_i,
    .rst_ni,
    .accept_i           (accept),
    .data_byte_i,
    .direction_i,
    .start_of_message_i,
    .message_length_i,
    .req_o              (req)
  );

  // pending read requests, matched by message id
  smbt_pend_table #(.PENDING_ENTRIES(PENDING_ENTRIES)) u_table (
    .clk_i,
    .rst_ni,
    .req_i (req),
    .res_o (res)
  );

  // result register plus skid
  smbt_out_buf u_out (
    .clk_i,
    .rst_ni,
    .res_i       (res),
    .out_ready_i,
    .in_ready_o,
    .out_o       (out)
  );

  assign out_valid_o     = out.valid;
  assign result_kind_o   = out.kind;
  assign message_id_o    = out.msg_id;
  assign file_id_low_o   = out.hlo;
  assign file_id_high_o  = out.hhi;
  assign file_pos_o      = out.fpos;
  assign payload_start_o = out.dstart;
  assign payload_len_o   = out.dlen;

endmodule

// ===== src/smbt_parser.sv =====
// compound header and body field walker, one byte per cycle while accept_i is high
module smbt_parser import smbt_pkg::*; #(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        direction_i,
  input  logic        start_of_message_i,
  input  logic [23:0] message_length_i,
  output req_t        req_o
);

  localparam int LW = LENGTH_BITS;

  logic [LW-1:0] pos_q, pos_d, hs_q, hs_d;
  phase_e        phase_q, phase_d;
  logic [15:0]   cmd_q, cmd_d;
  logic          resp_q, resp_d;
  logic [31:0]   nho_q, nho_d;
  logic [63:0]   mid_q, mid_d;
  logic [15:0]   po_q, po_d;
  logic [31:0]   pl_q, pl_d;
  logic [63:0]   fpos_q, fpos_d, hlo_q, hlo_d, hhi_q, hhi_d;
  logic [LW-1:0] msg_len;

  assign msg_len = LW'(message_length_i);

  always_comb begin
    logic [LW-1:0] pos, hs, rel, k;
    phase_e        ph;
    logic [32:0]   hdr_end, blen;
    logic          fits;
    pos     = pos_q;
    hs      = hs_q;
    ph      = phase_q;
    rel     = '0;
    k       = '0;
    hdr_end = '0;
    blen    = '0;
    fits    = 1'b0;
    cmd_d   = cmd_q;
    resp_d  = resp_q;
    nho_d   = nho_q;
    mid_d   = mid_q;
    po_d    = po_q;
    pl_d    = pl_q;
    fpos_d  = fpos_q;
    hlo_d   = hlo_q;
    hhi_d   = hhi_q;
    req_o   = '0;
    if (accept_i && (start_of_message_i || phase_q != PH_IDLE)) begin
      if (start_of_message_i) begin
        pos = '0;
        hs  = '0;
        ph  = ({1'b0, msg_len} < (LW+1)'(HDR_BYTES)) ? PH_DONE : PH_HEADER;
      end else begin
        pos = pos_q + 1'b1;
      end
      // next compound header begins
      if (ph == PH_BODY && nho_q != '0 && 33'(pos) == 33'(hs) + 33'(nho_q)) begin
        hs = pos;
        ph = ({1'b0, msg_len} < {1'b0, pos} + (LW+1)'(HDR_BYTES)) ? PH_DONE : PH_HEADER;
      end
      rel = pos - hs;
      if (ph == PH_HEADER) begin
        if (rel < LW'(4)) begin
          if (data_byte_i != magic_byte(rel[1:0])) ph = PH_DONE;
        end else if (rel == LW'(12)) begin
          cmd_d[7:0] = data_byte_i;
        end else if (rel == LW'(13)) begin
          cmd_d[15:8] = data_byte_i;
        end else if (rel == LW'(16)) begin
          resp_d = data_byte_i[0];
        end else if (rel >= LW'(20) && rel < LW'(24)) begin
          nho_d[{rel[1:0], 3'b000} +: 8] = data_byte_i;
        end else if (rel >= LW'(24) && rel < LW'(32)) begin
          mid_d[{rel[2:0], 3'b000} +: 8] = data_byte_i;
        end else if (rel == LW'(HDR_BYTES - 1)) begin
          ph = (nho_q != '0 && nho_q < 32'(HDR_BYTES)) ? PH_DONE : PH_BODY;
        end
      end else if (ph == PH_BODY && rel >= LW'(HDR_BYTES)) begin
        k = rel - LW'(HDR_BYTES);
        if (k == LW'(2)) begin
          po_d[7:0] = data_byte_i;
        end else if (k == LW'(3)) begin
          po_d[15:8] = data_byte_i;
        end else if (k >= LW'(4) && k < LW'(8)) begin
          pl_d[{k[1:0], 3'b000} +: 8] = data_byte_i;
        end else if (k >= LW'(8) && k < LW'(16)) begin
          fpos_d[{k[2:0], 3'b000} +: 8] = data_byte_i;
        end else if (k >= LW'(16) && k < LW'(24)) begin
          hlo_d[{k[2:0], 3'b000} +: 8] = data_byte_i;
        end else if (k >= LW'(24) && k < LW'(32)) begin
          hhi_d[{k[2:0], 3'b000} +: 8] = data_byte_i;
        end
        // body length and payload bounds
        hdr_end = 33'(hs) + 33'(HDR_BYTES);
        if (nho_q == '0) begin
          blen = (33'(msg_len) > hdr_end) ? 33'(msg_len) - hdr_end : '0;
        end else begin
          blen = 33'(nho_q) - 33'(HDR_BYTES);
        end
        fits = (po_d >= 16'(HDR_BYTES)) &&
               (34'(blen) >= 34'(po_d - 16'(HDR_BYTES)) + 34'(pl_d));
        if (resp_q) begin
          req_o.match = (k == LW'(7)) && cmd_q == CMD_READ && direction_i &&
                        blen >= 33'(READ_RSP_MIN) && fits;
        end else if (k == LW'(31) && !direction_i) begin
          req_o.record = cmd_q == CMD_READ && blen >= 33'(READ_REQ_MIN);
          req_o.write  = cmd_q == CMD_WRITE && blen >= 33'(WRITE_REQ_MIN) && fits;
        end
        req_o.msg_id = mid_q;
        req_o.hlo    = hlo_d;
        req_o.hhi    = hhi_d;
        req_o.fpos   = fpos_d;
        req_o.dstart = OUT_LEN_W'(hs + LW'(po_d));
        req_o.dlen   = pl_d[OUT_LEN_W-1:0];
      end
    end
    pos_d   = pos;
    hs_d    = hs;
    phase_d = ph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hs_q    <= '0;
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      resp_q  <= 1'b0;
      nho_q   <= '0;
      mid_q   <= '0;
      po_q    <= '0;
      pl_q    <= '0;
      fpos_q  <= '0;
      hlo_q   <= '0;
      hhi_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      hs_q    <= hs_d;
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      resp_q  <= resp_d;
      nho_q   <= nho_d;
      mid_q   <= mid_d;
      po_q    <= po_d;
      pl_q    <= pl_d;
      fpos_q  <= fpos_d;
      hlo_q   <= hlo_d;
      hhi_q   <= hhi_d;
    end
  end

endmodule

// ===== src/smbt_pend_table.sv =====
// pending read table with parallel id match
module smbt_pend_table import smbt_pkg::*; #(
  parameter int PENDING_ENTRIES = DEF_PENDING_ENTRIES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  output res_t res_o
);

  localparam int N  = PENDING_ENTRIES;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]  vld_q;
  logic [63:0]   id_q   [N];
  logic [63:0]   hlo_q  [N];
  logic [63:0]   hhi_q  [N];
  logic [63:0]   fpos_q [N];

  logic          hit, free;
  logic [IW-1:0] hit_idx, free_idx, slot;
  logic          found;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vld_q[i] && id_q[i] == req_i.msg_id) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!vld_q[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign found = hit || free;
  assign slot  = hit ? hit_idx : free_idx;

  always_comb begin
    res_o = '0;
    if (req_i.write) begin
      res_o.valid  = 1'b1;
      res_o.kind   = KIND_WRITE;
      res_o.msg_id = req_i.msg_id;
      res_o.hlo    = req_i.hlo;
      res_o.hhi    = req_i.hhi;
      res_o.fpos   = req_i.fpos;
      res_o.dstart = req_i.dstart;
      res_o.dlen   = req_i.dlen;
    end else if (req_i.record && !found) begin
      res_o.valid  = 1'b1;
      res_o.kind   = KIND_DROP;
      res_o.msg_id = req_i.msg_id;
      res_o.hlo    = req_i.hlo;
      res_o.hhi    = req_i.hhi;
      res_o.fpos   = req_i.fpos;
    end else if (req_i.match && hit) begin
      res_o.valid  = 1'b1;
      res_o.kind   = KIND_MATCH;
      res_o.msg_id = req_i.msg_id;
      res_o.hlo    = hlo_q[hit_idx];
      res_o.hhi    = hhi_q[hit_idx];
      res_o.fpos   = fpos_q[hit_idx];
      res_o.dstart = req_i.dstart;
      res_o.dlen   = req_i.dlen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.record && found) begin
      vld_q[slot] <= 1'b1;
    end else if (req_i.match && hit) begin
      vld_q[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.record && found) begin
      id_q[slot]   <= req_i.msg_id;
      hlo_q[slot]  <= req_i.hlo;
      hhi_q[slot]  <= req_i.hhi;
      fpos_q[slot] <= req_i.fpos;
    end
  end

  a_record_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.record && found |=> vld_q[$past(slot)] && id_q[$past(slot)] == $past(req_i.msg_id))
    else $error("recorded read not stored");

  a_match_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.match && hit |=> !vld_q[$past(hit_idx)])
    else $error("matched entry still pending");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == KIND_DROP |-> &vld_q)
    else $error("read dropped with free entry");

endmodule

// ===== src/smbt_out_buf.sv =====
// result register with one skid entry
module smbt_out_buf import smbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output res_t out_o
);

  logic out_v_q, out_v_d, skid_v_q, skid_v_d;
  res_t out_q, out_d, skid_q, skid_d;

  assign in_ready_o = !skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = res_i.valid;
        out_d   = res_i;
      end
    end else if (res_i.valid) begin
      skid_v_d = 1'b1;
      skid_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_comb begin
    out_o       = out_q;
    out_o.valid = out_v_q;
  end

endmodule
